### design/congestion_aware_next_hop_select_defines.svh
// Assertion macros used by the datapath (canhs_dp)
`ifndef CONGESTION_AWARE_NEXT_HOP_SELECT_DEFINES_SVH
`define CONGESTION_AWARE_NEXT_HOP_SELECT_DEFINES_SVH

`ifndef SYNTHESIS
`define CANHS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CANHS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CANHS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define CANHS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### design/canhs_pkg.sv
package canhs_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int IDX_W = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int RR_W  = $clog2(MAX_NEIGHBORS + 2);

    localparam int OP_W       = 2;
    localparam int ID_W       = 16;
    localparam int LVL_W      = 9;
    localparam int PRI_W      = 16;
    localparam int SP_W       = 15;
    localparam int Q_W        = 6;
    localparam int E_W        = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [LVL_W-1:0] LEVEL_INIT = 9'd300;
    localparam logic [LVL_W-1:0] LEVEL_NONE = 9'd300;

    localparam logic [ID_W-1:0]  RST_NODE_ID     = 16'd1;
    localparam logic [Q_W-1:0]   RST_Q_ENTER     = 6'd16;
    localparam logic [Q_W-1:0]   RST_Q_EXIT      = 6'd15;
    localparam logic [E_W-1:0]   RST_ENERGY      = 7'd25;
    localparam logic [SP_W-1:0]  RST_START_PRI   = 15'd500;
    localparam logic [LVL_W-1:0] RST_LEARNED_LVL = 9'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_ENTER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_EXIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PRI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNED_LVL = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_BEACON     = 2'd0,
        OP_ACK        = 2'd1,
        OP_DATA       = 2'd2,
        OP_SINK_START = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_DECODE,
        MODE_FIND,
        MODE_INSERT,
        MODE_MIN,
        MODE_BEACON,
        MODE_ACK,
        MODE_LOW,
        MODE_CONG,
        MODE_CAND,
        MODE_RRFIX,
        MODE_PICK,
        MODE_OUT
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  restart;
        logic  load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic own;
        logic for_me;
        logic at_end;
        logic hit;
        logic single;
        logic multi;
        logic out_free;
    } stat_t;

endpackage

### design/canhs_ctrl.sv
module canhs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  canhs_pkg::stat_t stat,
    output canhs_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_INSERT,
        ST_MIN,
        ST_BEACON,
        ST_ACK,
        ST_LOW,
        ST_CONG,
        ST_CAND,
        ST_RRFIX,
        ST_PICK,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    canhs_pkg::mode_t mode;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (stat.op)
                    canhs_pkg::OP_BEACON:     state_next = stat.own ? ST_OUT : ST_FIND;
                    canhs_pkg::OP_ACK:
                        state_next = (stat.own || !stat.for_me) ? ST_OUT : ST_ACK;
                    canhs_pkg::OP_DATA:       state_next = ST_FIND;
                    canhs_pkg::OP_SINK_START: state_next = ST_BEACON;
                    default:                  state_next = ST_OUT;
                endcase
            end
            ST_FIND:
            begin
                if (stat.at_end)
                    state_next = ST_INSERT;
                else if (stat.hit)
                    state_next = (stat.op == canhs_pkg::OP_BEACON) ? ST_MIN : ST_LOW;
            end
            ST_INSERT: state_next = (stat.op == canhs_pkg::OP_BEACON) ? ST_MIN : ST_LOW;
            ST_MIN:
            begin
                if (stat.at_end)
                    state_next = ST_BEACON;
            end
            ST_BEACON: state_next = ST_OUT;
            ST_ACK:
            begin
                if (stat.at_end)
                    state_next = ST_OUT;
            end
            ST_LOW:
            begin
                if (stat.at_end)
                    state_next = ST_CONG;
            end
            ST_CONG: state_next = stat.multi ? ST_CAND : ST_OUT;
            ST_CAND:
            begin
                if (stat.at_end)
                    state_next = ST_RRFIX;
            end
            ST_RRFIX: state_next = ST_PICK;
            ST_PICK:
            begin
                if (stat.at_end)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   mode = canhs_pkg::MODE_IDLE;
            ST_DECODE: mode = canhs_pkg::MODE_DECODE;
            ST_FIND:   mode = canhs_pkg::MODE_FIND;
            ST_INSERT: mode = canhs_pkg::MODE_INSERT;
            ST_MIN:    mode = canhs_pkg::MODE_MIN;
            ST_BEACON: mode = canhs_pkg::MODE_BEACON;
            ST_ACK:    mode = canhs_pkg::MODE_ACK;
            ST_LOW:    mode = canhs_pkg::MODE_LOW;
            ST_CONG:   mode = canhs_pkg::MODE_CONG;
            ST_CAND:   mode = canhs_pkg::MODE_CAND;
            ST_RRFIX:  mode = canhs_pkg::MODE_RRFIX;
            ST_PICK:   mode = canhs_pkg::MODE_PICK;
            ST_OUT:    mode = canhs_pkg::MODE_OUT;
            default:   mode = canhs_pkg::MODE_IDLE;
        endcase
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.mode    = mode;
    assign cmd.restart = (state_next != state_reg);
    assign cmd.load    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/canhs_dp.sv
`include "congestion_aware_next_hop_select_defines.svh"

module canhs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [canhs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [canhs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [canhs_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [canhs_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [canhs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  canhs_pkg::cmd_t                     cmd,
    output canhs_pkg::stat_t                    stat
);

    localparam int MAXN  = canhs_pkg::MAX_NEIGHBORS;
    localparam int IDX_W = canhs_pkg::IDX_W;
    localparam int CNT_W = canhs_pkg::CNT_W;
    localparam int RR_W  = canhs_pkg::RR_W;
    localparam int ID_W  = canhs_pkg::ID_W;
    localparam int LVL_W = canhs_pkg::LVL_W;
    localparam int PRI_W = canhs_pkg::PRI_W;
    localparam int Q_W   = canhs_pkg::Q_W;
    localparam int E_W   = canhs_pkg::E_W;
    localparam int SP_W  = canhs_pkg::SP_W;

    logic [ID_W-1:0]  id_reg  [MAXN];
    logic [ID_W-1:0]  id_next [MAXN];
    logic [LVL_W-1:0] lvl_reg [MAXN];
    logic [LVL_W-1:0] lvl_next[MAXN];
    logic             rdy_reg [MAXN];
    logic             rdy_next[MAXN];
    logic [PRI_W-1:0] pri_reg [MAXN];
    logic [PRI_W-1:0] pri_next[MAXN];

    logic [ID_W-1:0]  node_id_reg, node_id_next;
    logic [Q_W-1:0]   q_enter_reg, q_enter_next;
    logic [Q_W-1:0]   q_exit_reg, q_exit_next;
    logic [E_W-1:0]   e_limit_reg, e_limit_next;
    logic [SP_W-1:0]  start_pri_reg, start_pri_next;
    logic [LVL_W-1:0] learned_reg, learned_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [LVL_W-1:0] own_level_reg, own_level_next;
    logic             cong_reg, cong_next;
    logic [RR_W-1:0]  rr_reg, rr_next;
    logic             pending_reg, pending_next;

    canhs_pkg::op_t   op_reg, op_next;
    logic [ID_W-1:0]  nid_reg, nid_next;
    logic [LVL_W-1:0] nlev_reg, nlev_next;
    logic             nrdy_reg, nrdy_next;
    logic             for_me_reg, for_me_next;
    logic [Q_W-1:0]   queue_reg, queue_next;
    logic [E_W-1:0]   energy_reg, energy_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [LVL_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0] lower_reg, lower_next;
    logic [CNT_W-1:0] unavail_reg, unavail_next;
    logic [CNT_W-1:0] cands_reg, cands_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [PRI_W-1:0] maxp_reg, maxp_next;
    logic             seen_reg, seen_next;
    logic             first_reg, first_next;
    logic             picked_reg, picked_next;
    logic [ID_W-1:0]  hop_reg, hop_next;
    logic             ok_reg, ok_next;
    logic             notify_reg, notify_next;
    logic             beacon_reg, beacon_next;
    logic             full_reg, full_next;

    logic                             out_valid_reg, out_valid_next;
    logic [canhs_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [IDX_W-1:0] ptr;
    logic [ID_W-1:0]  cur_id;
    logic [LVL_W-1:0] cur_lvl;
    logic             cur_rdy;
    logic [PRI_W-1:0] cur_pri;
    logic             at_end;
    logic             is_lower;
    logic             is_cand;
    logic             out_free;
    logic             c;

    assign ptr      = idx_reg[IDX_W-1:0];
    assign cur_id   = id_reg[ptr];
    assign cur_lvl  = lvl_reg[ptr];
    assign cur_rdy  = rdy_reg[ptr];
    assign cur_pri  = pri_reg[ptr];
    assign at_end   = (idx_reg == count_reg);
    assign is_lower = !at_end && (cur_lvl < own_level_reg);
    assign is_cand  = is_lower && (cur_pri == maxp_reg);
    assign out_free = !out_valid_reg || m_tready;

    assign stat.op       = op_reg;
    assign stat.own      = (nid_reg == node_id_reg);
    assign stat.for_me   = for_me_reg;
    assign stat.at_end   = at_end;
    assign stat.hit      = !at_end && (cur_id == nid_reg);
    assign stat.single   = (lower_reg == CNT_W'(1));
    assign stat.multi    = (lower_reg > CNT_W'(1));
    assign stat.out_free = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        id_next  = id_reg;
        lvl_next = lvl_reg;
        rdy_next = rdy_reg;
        pri_next = pri_reg;

        node_id_next   = node_id_reg;
        q_enter_next   = q_enter_reg;
        q_exit_next    = q_exit_reg;
        e_limit_next   = e_limit_reg;
        start_pri_next = start_pri_reg;
        learned_next   = learned_reg;

        count_next     = count_reg;
        own_level_next = own_level_reg;
        cong_next      = cong_reg;
        rr_next        = rr_reg;
        pending_next   = pending_reg;

        op_next     = op_reg;
        nid_next    = nid_reg;
        nlev_next   = nlev_reg;
        nrdy_next   = nrdy_reg;
        for_me_next = for_me_reg;
        queue_next  = queue_reg;
        energy_next = energy_reg;

        min_next     = min_reg;
        lower_next   = lower_reg;
        unavail_next = unavail_reg;
        cands_next   = cands_reg;
        k_next       = k_reg;
        maxp_next    = maxp_reg;
        seen_next    = seen_reg;
        first_next   = first_reg;
        picked_next  = picked_reg;
        hop_next     = hop_reg;
        ok_next      = ok_reg;
        notify_next  = notify_reg;
        beacon_next  = beacon_reg;
        full_next    = full_reg;
        c            = cong_reg;

        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.restart)
            idx_next = '0;
        else if (!at_end)
            idx_next = idx_reg + CNT_W'(1);
        else
            idx_next = idx_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                canhs_pkg::CFG_NODE_ID:     node_id_next   = cfg_data[ID_W-1:0];
                canhs_pkg::CFG_Q_ENTER:     q_enter_next   = cfg_data[Q_W-1:0];
                canhs_pkg::CFG_Q_EXIT:      q_exit_next    = cfg_data[Q_W-1:0];
                canhs_pkg::CFG_ENERGY:      e_limit_next   = cfg_data[E_W-1:0];
                canhs_pkg::CFG_START_PRI:   start_pri_next = cfg_data[SP_W-1:0];
                canhs_pkg::CFG_LEARNED_LVL: learned_next   = cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            op_next      = canhs_pkg::op_t'(s_tuser);
            nid_next     = s_tdata[15:0];
            nlev_next    = s_tdata[24:16];
            nrdy_next    = s_tdata[25];
            for_me_next  = s_tdata[26];
            queue_next   = s_tdata[32:27];
            energy_next  = s_tdata[39:33];
            min_next     = canhs_pkg::LEVEL_NONE;
            lower_next   = '0;
            unavail_next = '0;
            cands_next   = '0;
            k_next       = '0;
            maxp_next    = '0;
            seen_next    = 1'b0;
            first_next   = 1'b0;
            picked_next  = 1'b0;
            hop_next     = '0;
            ok_next      = 1'b0;
            notify_next  = 1'b0;
            beacon_next  = 1'b0;
            full_next    = 1'b0;
        end

        case (cmd.mode)
            canhs_pkg::MODE_INSERT:
            begin
                if (count_reg >= CNT_W'(MAXN))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    for (int i = 1; i < MAXN; i++)
                    begin
                        id_next[i]  = id_reg[i-1];
                        lvl_next[i] = lvl_reg[i-1];
                        rdy_next[i] = rdy_reg[i-1];
                        pri_next[i] = pri_reg[i-1];
                    end
                    id_next[0]  = nid_reg;
                    lvl_next[0] = (op_reg == canhs_pkg::OP_DATA) ? learned_reg : nlev_reg;
                    rdy_next[0] = (op_reg == canhs_pkg::OP_DATA) ? 1'b1 : nrdy_reg;
                    pri_next[0] = PRI_W'(start_pri_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            canhs_pkg::MODE_MIN:
            begin
                if (!at_end && (cur_lvl < min_reg))
                    min_next = cur_lvl;
            end
            canhs_pkg::MODE_BEACON:
            begin
                if (op_reg == canhs_pkg::OP_BEACON)
                    own_level_next = min_reg + LVL_W'(1);
                if (node_id_reg == '0)
                    own_level_next = '0;
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    beacon_next  = 1'b1;
                end
            end
            canhs_pkg::MODE_ACK:
            begin
                if (!at_end && (cur_id == nid_reg))
                begin
                    lvl_next[ptr] = nlev_reg;
                    rdy_next[ptr] = nrdy_reg;
                    if (cur_pri != '0)
                        pri_next[ptr] = cur_pri - PRI_W'(1);
                end
            end
            canhs_pkg::MODE_LOW:
            begin
                if (is_lower)
                begin
                    lower_next = lower_reg + CNT_W'(1);
                    if (!cur_rdy)
                        unavail_next = unavail_reg + CNT_W'(1);
                    if (!first_reg)
                    begin
                        first_next = 1'b1;
                        hop_next   = cur_id;
                        ok_next    = cur_rdy;
                    end
                    if (!seen_reg || (cur_pri > maxp_reg))
                    begin
                        seen_next = 1'b1;
                        maxp_next = cur_pri;
                    end
                end
            end
            canhs_pkg::MODE_CONG:
            begin
                if (queue_reg > q_enter_reg)
                    c = 1'b1;
                if (energy_reg < e_limit_reg)
                    c = 1'b1;
                if (unavail_reg >= lower_reg)
                    c = 1'b1;
                if ((queue_reg <= q_exit_reg) && (energy_reg >= e_limit_reg)
                    && (unavail_reg < lower_reg))
                    c = 1'b0;
                if (node_id_reg == '0)
                    c = 1'b0;
                cong_next   = c;
                notify_next = (c != cong_reg);
            end
            canhs_pkg::MODE_CAND:
            begin
                if (is_cand)
                    cands_next = cands_reg + CNT_W'(1);
            end
            canhs_pkg::MODE_RRFIX:
            begin
                if ((rr_reg == '0) || (rr_reg > RR_W'(cands_reg)))
                    rr_next = RR_W'(1);
            end
            canhs_pkg::MODE_PICK:
            begin
                if (is_cand)
                begin
                    k_next = k_reg + CNT_W'(1);
                    if (!picked_reg && ((RR_W'(k_reg) + RR_W'(1)) == rr_reg))
                    begin
                        picked_next = 1'b1;
                        hop_next    = cur_id;
                        ok_next     = cur_rdy;
                    end
                end
                if (at_end)
                    rr_next = rr_reg + RR_W'(1);
            end
            canhs_pkg::MODE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, full_reg, own_level_reg, beacon_reg,
                                      notify_reg, cong_reg, ok_reg, hop_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg   <= canhs_pkg::RST_NODE_ID;
            q_enter_reg   <= canhs_pkg::RST_Q_ENTER;
            q_exit_reg    <= canhs_pkg::RST_Q_EXIT;
            e_limit_reg   <= canhs_pkg::RST_ENERGY;
            start_pri_reg <= canhs_pkg::RST_START_PRI;
            learned_reg   <= canhs_pkg::RST_LEARNED_LVL;
            count_reg     <= '0;
            own_level_reg <= canhs_pkg::LEVEL_INIT;
            cong_reg      <= 1'b0;
            rr_reg        <= RR_W'(1);
            pending_reg   <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            node_id_reg   <= node_id_next;
            q_enter_reg   <= q_enter_next;
            q_exit_reg    <= q_exit_next;
            e_limit_reg   <= e_limit_next;
            start_pri_reg <= start_pri_next;
            learned_reg   <= learned_next;
            count_reg     <= count_next;
            own_level_reg <= own_level_next;
            cong_reg      <= cong_next;
            rr_reg        <= rr_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        lvl_reg      <= lvl_next;
        rdy_reg      <= rdy_next;
        pri_reg      <= pri_next;
        op_reg       <= op_next;
        nid_reg      <= nid_next;
        nlev_reg     <= nlev_next;
        nrdy_reg     <= nrdy_next;
        for_me_reg   <= for_me_next;
        queue_reg    <= queue_next;
        energy_reg   <= energy_next;
        min_reg      <= min_next;
        lower_reg    <= lower_next;
        unavail_reg  <= unavail_next;
        cands_reg    <= cands_next;
        k_reg        <= k_next;
        maxp_reg     <= maxp_next;
        seen_reg     <= seen_next;
        first_reg    <= first_next;
        picked_reg   <= picked_next;
        hop_reg      <= hop_next;
        ok_reg       <= ok_next;
        notify_reg   <= notify_next;
        beacon_reg   <= beacon_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    `CANHS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAXN))
    `CANHS_ASSERT_NEXT(a_beacon_once, clk, rst_n, !pending_reg, !pending_reg)
    `CANHS_ASSERT_NOW(a_rr_bound, clk, rst_n, 1'b1, rr_reg <= RR_W'(MAXN + 1))
    `CANHS_ASSERT_NOW(a_idx_bound, clk, rst_n, 1'b1, idx_reg <= count_reg)

endmodule

### design/congestion_aware_next_hop_select.sv
// Neighbour table and next-hop selection for a sensor node.
// Input channel s_*: one transaction per packet event; tuser carries the
// operation (beacon, ack, data, sink start), tdata the neighbour and local
// status fields. Output channel m_*: exactly one result transaction per
// input transaction, carrying next hop, forward flag, congestion state,
// notify and beacon flags, own level and the table-full flag.
// Configuration: cfg_we writes cfg_data into register cfg_index; write
// only while no transaction is in flight.
// Sequencing: one item at a time through a table-scan sequencer. Each scan
// walks the table one entry per cycle. An ack runs an update scan, a beacon
// a lookup and a level scan, and data a lookup, occupancy scan, candidate
// count and pick; the output handshake follows.
// Reset: table empty, own level 300, not congested, beacon pending,
// configuration at its defaults; no clearing pass is needed.
// Stall: the result is held in an output register until m_tready; the
// sequencer waits in its final step only while that register is still full.
module congestion_aware_next_hop_select (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [canhs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [canhs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // neighbor_id, neighbor_level, neighbor_ready, ack_for_me, queue_length, energy_percent
    input  logic [canhs_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic [canhs_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // next_hop, forward_ok, congested, notify_neighbors, emit_beacon, node_level,
    // table_full, zero padding
    output logic [canhs_pkg::OUT_DATA_W-1:0]    m_tdata
);

    canhs_pkg::cmd_t  cmd;
    canhs_pkg::stat_t stat;

    canhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    canhs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
